### rtl/core/rgba_color_matrix_filter_unit_defines.svh
// Assertion macros shared by the checker of the color matrix filter.
// Depends on signals clk and rst_n being visible where a macro is used.
`ifndef RGBA_COLOR_MATRIX_FILTER_UNIT_DEFINES_SVH
`define RGBA_COLOR_MATRIX_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is held
`define CMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("color matrix checker: property failed");

// Next-cycle implication, off while reset is held
`define CMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("color matrix checker: property failed");

// Next-cycle implication that also covers reset cycles
`define CMF_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("color matrix checker: property failed");

`endif

### rtl/core/cmf_pkg.sv
// Shared constants and types of the RGBA color matrix filter.
// No dependencies; used by every module of the block.
`default_nettype none

package cmf_pkg;

  // Pixel and coefficient format
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int NUM_TERMS  = 5;
  localparam int COEF_BITS  = 12;
  localparam int FRAC_BITS  = 8;
  localparam int REG_W      = 60;
  localparam int CFG_IDX_W  = 3;
  localparam int DATA_W     = NUM_CH * CH_W;

  // Product: 9-bit signed channel times signed coefficient
  localparam int PROD_W     = COEF_BITS + CH_W + 1;
  // Sum of five products
  localparam int SUM_W      = PROD_W + 3;

  localparam int CHAN_MAX   = 255;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RED   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GREEN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BLUE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = CFG_IDX_W'(3);

  // Reset rows: identity matrix, gain 1.0 on the diagonal
  localparam logic [REG_W-1:0] RST_RED   = REG_W'(1) << FRAC_BITS;
  localparam logic [REG_W-1:0] RST_GREEN = REG_W'(1) << (COEF_BITS + FRAC_BITS);
  localparam logic [REG_W-1:0] RST_BLUE  = REG_W'(1) << (2 * COEF_BITS + FRAC_BITS);
  localparam logic [REG_W-1:0] RST_ALPHA = REG_W'(1) << (3 * COEF_BITS + FRAC_BITS);

  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;
  typedef logic [REG_W-1:0] row_t;

  // Pipeline control travelling next to the lanes
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

`default_nettype wire

### rtl/core/cmf_lane.sv
// One output channel of the color matrix: products, sum and clamp.
// Depends on cmf_pkg.
`default_nettype none

module cmf_lane (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire cmf_pkg::pixel_t       pix,
  input  wire cmf_pkg::row_t         row,
  output logic [cmf_pkg::CH_W-1:0]   chan
);

  logic signed [cmf_pkg::PROD_W-1:0] prod_r   [cmf_pkg::NUM_TERMS];
  logic signed [cmf_pkg::PROD_W-1:0] prod_nxt [cmf_pkg::NUM_TERMS];
  logic signed [cmf_pkg::SUM_W-1:0]  sum;

  // Stage 1: one multiplier per term, offset term uses the channel maximum
  always_comb begin
    logic signed [cmf_pkg::COEF_BITS-1:0] coef;
    logic signed [cmf_pkg::CH_W:0]        opnd;
    for (int k = 0; k < cmf_pkg::NUM_TERMS; k++) begin
      coef = $signed(row[k*cmf_pkg::COEF_BITS +: cmf_pkg::COEF_BITS]);
      if (k < cmf_pkg::NUM_CH) begin
        opnd = $signed({1'b0, pix[k]});
      end else begin
        opnd = $signed((cmf_pkg::CH_W + 1)'(cmf_pkg::CHAN_MAX));
      end
      prod_nxt[k] = cmf_pkg::PROD_W'(opnd * coef);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < cmf_pkg::NUM_TERMS; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
    end
  end

  // Stage 2: full-width sum, then clamp and drop the fraction
  always_comb begin
    sum = '0;
    for (int k = 0; k < cmf_pkg::NUM_TERMS; k++) begin
      sum = sum + cmf_pkg::SUM_W'(prod_r[k]);
    end
    if (sum < 0) begin
      chan = '0;
    end else if (sum >= $signed(cmf_pkg::SUM_W'(cmf_pkg::CHAN_MAX << cmf_pkg::FRAC_BITS))) begin
      chan = cmf_pkg::CH_W'(cmf_pkg::CHAN_MAX);
    end else begin
      chan = sum[cmf_pkg::FRAC_BITS +: cmf_pkg::CH_W];
    end
  end

endmodule

`default_nettype wire

### rtl/core/cmf_merge.sv
// Output register: joins the four lane results into one result transfer.
// Depends on cmf_pkg.
`default_nettype none

module cmf_merge (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire cmf_pkg::ctl_t              ctl,
  input  wire cmf_pkg::pixel_t            chans,
  output logic                            out_tvalid,
  output logic [cmf_pkg::DATA_W-1:0]      out_tdata,
  output logic                            out_tlast
);

  logic                        valid_r;
  logic                        last_r;
  logic [cmf_pkg::DATA_W-1:0]  data_r;

  // Control: valid follows the pipeline when it moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl.valid;
    end
  end

  // Payload: red in the low byte up to alpha in the high byte
  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= chans;
      last_r <= ctl.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

### rtl/core/rgba_color_matrix_filter_unit.sv
// Top level of the RGBA 4x5 color matrix filter: config rows, four lanes, output register.
// Depends on cmf_pkg, cmf_lane and cmf_merge.
//
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready  | in_tdata (R,G,B,A), in_tlast (frame end)
//  out_    | master    | out_tvalid / out_tready| out_tdata (R,G,B,A), out_tlast (frame end)
//  cfg_    | write     | cfg_wr_en              | cfg_index, cfg_wdata (one 60-bit row)
//
// One pixel per clock while the output is not stalled; each pixel passes the product
// register, then the output register after the sum and clamp.
// All stages move together; they hold only when out_tvalid is high and
// out_tready is low, so in_tready = !out_tvalid || out_tready.
// rst_n (synchronous) empties the pipeline and loads the identity matrix.
`default_nettype none

module rgba_color_matrix_filter_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: red [7:0], green [15:8], blue [23:16], alpha [31:24]
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [cmf_pkg::DATA_W-1:0]       in_tdata,
  input  wire logic                             in_tlast,
  // out_tdata: red [7:0], green [15:8], blue [23:16], alpha [31:24]
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [cmf_pkg::DATA_W-1:0]            out_tdata,
  output logic                                  out_tlast,
  input  wire logic                             cfg_wr_en,
  input  wire logic [cmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cmf_pkg::REG_W-1:0]        cfg_wdata
);

  cmf_pkg::row_t   row_r [cmf_pkg::NUM_CH];
  cmf_pkg::ctl_t   ctl1_r;
  cmf_pkg::pixel_t pix;
  cmf_pkg::pixel_t chans;
  logic            adv;

  // Pipeline advances unless a finished result is stalled
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign pix       = in_tdata;

  // Coefficient rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= cmf_pkg::RST_RED;
      row_r[1] <= cmf_pkg::RST_GREEN;
      row_r[2] <= cmf_pkg::RST_BLUE;
      row_r[3] <= cmf_pkg::RST_ALPHA;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cmf_pkg::REG_RED:   row_r[0] <= cfg_wdata;
        cmf_pkg::REG_GREEN: row_r[1] <= cfg_wdata;
        cmf_pkg::REG_BLUE:  row_r[2] <= cfg_wdata;
        cmf_pkg::REG_ALPHA: row_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
      ctl1_r.last  <= 1'b0;
    end else if (adv) begin
      ctl1_r.valid <= in_tvalid;
      ctl1_r.last  <= in_tlast;
    end
  end

  // One lane per output channel
  for (genvar c = 0; c < cmf_pkg::NUM_CH; c++) begin : g_lane
    cmf_lane u_lane (
      .clk  (clk),
      .en   (adv),
      .pix  (pix),
      .row  (row_r[c]),
      .chan (chans[c])
    );
  end

  cmf_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .ctl        (ctl1_r),
    .chans      (chans),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### rtl/core/cmf_checker.sv
// Port-level checker of the color matrix filter, bound to the top level.
// Depends on cmf_pkg and rgba_color_matrix_filter_unit_defines.svh.
`default_nettype none
`include "rgba_color_matrix_filter_unit_defines.svh"

module cmf_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [cmf_pkg::DATA_W-1:0]  out_tdata,
  input wire logic                        out_tlast
);

  // Input side stalls only behind a stalled result
  `CMF_ASSERT_NOW(a_ready_rule, 1'b1, in_tready == (!out_tvalid || out_tready))

  // A transfer in, with the output draining after it, shows up as a valid result
  `CMF_ASSERT_NEXT(a_latency, (in_tvalid && in_tready) ##1 out_tready, out_tvalid)

  // Reset empties the output
  `CMF_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid)

  // A stalled result holds its payload
  `CMF_ASSERT_NEXT(a_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind rgba_color_matrix_filter_unit cmf_checker u_cmf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
